// ===== design/rmq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types, widths and constants of the matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int RAD_W     = IN_W + 2;                       // signed radicand
    localparam int NUM_W     = IN_W + 1;                       // signed sum or difference
    localparam int ROOT_W    = (RAD_W - 1 + FRAC_BITS + 1) / 2;
    localparam int SQ_W      = 2 * ROOT_W;                     // padded root operand
    localparam int REM_W     = ROOT_W + 3;
    localparam int S_W       = ROOT_W + 1;
    localparam int N_W       = NUM_W + FRAC_BITS;              // scaled dividend
    localparam int Q_W       = IN_W;
    localparam int CMP_W     = S_W + Q_W;

    localparam logic signed [RAD_W-1:0] ONE = RAD_W'(1) <<< FRAC_BITS;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_M00   = 2'd1,
        BR_M11   = 2'd2,
        BR_M22   = 2'd3
    } t_branch;

    typedef struct packed {
        logic                        degen;
        t_branch                     branch;
        logic [2:0][NUM_W-1:0]       num;
    } t_side;

    typedef struct packed {
        logic           ovf;
        logic           neg;
        logic [Q_W-1:0] q;
    } t_quo;

endpackage

// ===== design/rmq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_front
// Branch choice, radicand and the three numerators, one register stage.
// ----------------------------------------------------------------------------
module rmq_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_vld,
    input  logic [9*rmq_pkg::IN_W-1:0]       i_mat,
    output logic                             o_vld,
    output logic [rmq_pkg::SQ_W-1:0]         o_rad,
    output rmq_pkg::t_side                   o_side
);

    logic signed [rmq_pkg::RAD_W-1:0] m [9];
    logic signed [rmq_pkg::RAD_W-1:0] t, rad;
    rmq_pkg::t_branch                 br;
    logic                             r_vld;
    logic [rmq_pkg::SQ_W-1:0]         r_rad;
    rmq_pkg::t_side                   r_side;
    rmq_pkg::t_side                   n_side;
    logic [rmq_pkg::SQ_W-1:0]         n_rad;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            m[k] = rmq_pkg::RAD_W'($signed(i_mat[k*rmq_pkg::IN_W +: rmq_pkg::IN_W]));
        end
        t = rmq_pkg::ONE + m[0] + m[4] + m[8];
        if (t > 0) begin
            br  = rmq_pkg::BR_TRACE;
            rad = t;
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            br  = rmq_pkg::BR_M00;
            rad = rmq_pkg::ONE + m[0] - m[4] - m[8];
        end else if (m[4] > m[8]) begin
            br  = rmq_pkg::BR_M11;
            rad = rmq_pkg::ONE + m[4] - m[0] - m[8];
        end else begin
            br  = rmq_pkg::BR_M22;
            rad = rmq_pkg::ONE + m[8] - m[0] - m[4];
        end
        n_side.branch = br;
        n_side.degen  = (rad <= 0);
        // Numerators in output order, skipping the component that takes r/2.
        case (br)
            rmq_pkg::BR_TRACE: begin
                n_side.num[0] = rmq_pkg::NUM_W'(m[7] - m[5]);
                n_side.num[1] = rmq_pkg::NUM_W'(m[2] - m[6]);
                n_side.num[2] = rmq_pkg::NUM_W'(m[3] - m[1]);
            end
            rmq_pkg::BR_M00: begin
                n_side.num[0] = rmq_pkg::NUM_W'(m[1] + m[3]);
                n_side.num[1] = rmq_pkg::NUM_W'(m[2] + m[6]);
                n_side.num[2] = rmq_pkg::NUM_W'(m[7] - m[5]);
            end
            rmq_pkg::BR_M11: begin
                n_side.num[0] = rmq_pkg::NUM_W'(m[3] + m[1]);
                n_side.num[1] = rmq_pkg::NUM_W'(m[7] + m[5]);
                n_side.num[2] = rmq_pkg::NUM_W'(m[2] - m[6]);
            end
            default: begin
                n_side.num[0] = rmq_pkg::NUM_W'(m[2] + m[6]);
                n_side.num[1] = rmq_pkg::NUM_W'(m[7] + m[5]);
                n_side.num[2] = rmq_pkg::NUM_W'(m[3] - m[1]);
            end
        endcase
        if (n_side.degen) begin
            n_rad = '0;
        end else begin
            n_rad = rmq_pkg::SQ_W'({rad[rmq_pkg::RAD_W-2:0], {rmq_pkg::FRAC_BITS{1'b0}}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_rad  <= n_rad;
            r_side <= n_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_rad  = r_rad;
    assign o_side = r_side;

endmodule

// ===== design/rmq_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one root bit per stage, with side data.
// ----------------------------------------------------------------------------
module rmq_sqrt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_vld,
    input  logic [rmq_pkg::SQ_W-1:0]         i_rad,
    input  rmq_pkg::t_side                   i_side,
    output logic                             o_vld,
    output logic [rmq_pkg::ROOT_W-1:0]       o_root,
    output rmq_pkg::t_side                   o_side
);

    localparam int NS = rmq_pkg::ROOT_W;

    logic                       r_vld  [NS];
    logic [rmq_pkg::SQ_W-1:0]   r_v    [NS];
    logic [rmq_pkg::REM_W-1:0]  r_rem  [NS];
    logic [rmq_pkg::ROOT_W-1:0] r_root [NS];
    rmq_pkg::t_side             r_side [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic                       p_vld;
        logic [rmq_pkg::SQ_W-1:0]   p_v;
        logic [rmq_pkg::REM_W-1:0]  p_rem, rem_sh, trial;
        logic [rmq_pkg::ROOT_W-1:0] p_root;
        rmq_pkg::t_side             p_side;
        logic [rmq_pkg::REM_W-1:0]  n_rem;
        logic [rmq_pkg::ROOT_W-1:0] n_root;

        if (k == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_v    = i_rad;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_v    = r_v[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_side = r_side[k-1];
        end

        always_comb begin
            rem_sh = {p_rem[rmq_pkg::REM_W-3:0], p_v[rmq_pkg::SQ_W-1 -: 2]};
            trial  = rmq_pkg::REM_W'({p_root, 2'b01});
            if (rem_sh >= trial) begin
                n_rem  = rem_sh - trial;
                n_root = {p_root[rmq_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_root = {p_root[rmq_pkg::ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
            if (i_en) begin
                r_v[k]    <= p_v << 2;
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_root = r_root[NS-1];
    assign o_side = r_side[NS-1];

endmodule

// ===== design/rmq_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divider, one quotient bit per stage, with overflow.
// ----------------------------------------------------------------------------
module rmq_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_vld,
    input  logic [rmq_pkg::NUM_W-1:0]        i_num,
    input  logic [rmq_pkg::S_W-1:0]          i_den,
    output logic                             o_vld,
    output rmq_pkg::t_quo                    o_quo
);

    localparam int NS = rmq_pkg::Q_W;

    logic                        r_vld [NS];
    logic [rmq_pkg::CMP_W-1:0]   r_n   [NS];
    logic [rmq_pkg::S_W-1:0]     r_s   [NS];
    rmq_pkg::t_quo               r_quo [NS];

    logic [rmq_pkg::NUM_W-1:0]   mag;
    logic [rmq_pkg::CMP_W-1:0]   n0;
    rmq_pkg::t_quo               quo0;

    always_comb begin
        mag  = i_num[rmq_pkg::NUM_W-1] ? (~i_num + 1'b1) : i_num;
        n0   = rmq_pkg::CMP_W'({mag, {rmq_pkg::FRAC_BITS{1'b0}}});
        quo0.neg = i_num[rmq_pkg::NUM_W-1];
        quo0.ovf = (n0 >= (rmq_pkg::CMP_W'(i_den) << rmq_pkg::Q_W));
        quo0.q   = '0;
    end

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam int SH = NS - 1 - k;
        logic                      p_vld;
        logic [rmq_pkg::CMP_W-1:0] p_n, dsh, n_n;
        logic [rmq_pkg::S_W-1:0]   p_s;
        rmq_pkg::t_quo             p_quo, n_quo;

        if (k == 0) begin : g_first
            assign p_vld = i_vld;
            assign p_n   = n0;
            assign p_s   = i_den;
            assign p_quo = quo0;
        end else begin : g_next
            assign p_vld = r_vld[k-1];
            assign p_n   = r_n[k-1];
            assign p_s   = r_s[k-1];
            assign p_quo = r_quo[k-1];
        end

        always_comb begin
            dsh   = rmq_pkg::CMP_W'(p_s) << SH;
            n_quo = p_quo;
            if (p_n >= dsh) begin
                n_n         = p_n - dsh;
                n_quo.q[SH] = 1'b1;
            end else begin
                n_n = p_n;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
            if (i_en) begin
                r_n[k]   <= n_n;
                r_s[k]   <= p_s;
                r_quo[k] <= n_quo;
            end
        end
    end

    assign o_vld = r_vld[NS-1];
    assign o_quo = r_quo[NS-1];

endmodule

// ===== design/rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation matrix to a unit quaternion by the trace method.
// ----------------------------------------------------------------------------
// Usage: each request on the slave channel carries the nine matrix elements
// (signed, 14 fraction bits); each request on the master channel carries one
// quaternion and a degenerate flag in tuser. One result follows each matrix,
// in order.
// From acceptance to tvalid, one stage picks the branch and forms the
// radicand, 16 stages of the square root produce one root bit each, 16 stages
// of the three parallel dividers produce one quotient bit each, and one stage
// saturates and places the components.
// Throughput is one matrix per cycle unless the receiver stalls; the
// pipeline advances as a whole and o_s_tready is high whenever the output
// register is empty or being taken. When the receiver stalls, every stage
// holds, so nothing is lost or repeated. Reset (synchronous, active low)
// clears all valid bits; data registers are not reset.
// A radicand of zero or less gives all components zero and tuser set.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each, lowest first)
    input  logic [143:0]  i_s_tdata,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // qx, qy, qz, qw (16 bits each, lowest first)
    output logic [63:0]   o_m_tdata,
    // degenerate
    output logic [0:0]    o_m_tuser
);

    localparam int DL = rmq_pkg::Q_W;

    // Global advance: the whole pipeline moves unless the output is blocked.
    logic en;
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    logic                        f_vld, s_vld;
    logic [rmq_pkg::SQ_W-1:0]    f_rad;
    rmq_pkg::t_side              f_side, s_side;
    logic [rmq_pkg::ROOT_W-1:0]  s_root;

    rmq_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (i_s_tvalid),
        .i_mat  (i_s_tdata),
        .o_vld  (f_vld),
        .o_rad  (f_rad),
        .o_side (f_side)
    );

    rmq_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (f_vld),
        .i_rad  (f_rad),
        .i_side (f_side),
        .o_vld  (s_vld),
        .o_root (s_root),
        .o_side (s_side)
    );

    // Three dividers share the divisor S = 2r.
    logic [rmq_pkg::S_W-1:0] den;
    logic [2:0]              d_vld;
    rmq_pkg::t_quo           d_quo [3];
    assign den = {s_root, 1'b0};

    for (genvar l = 0; l < 3; l++) begin : g_lane
        rmq_div u_div (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_vld  (s_vld),
            .i_num  (s_side.num[l]),
            .i_den  (den),
            .o_vld  (d_vld[l]),
            .o_quo  (d_quo[l])
        );
    end

    // Branch, flag and r/2 travel alongside the dividers.
    logic                         r_dl_degen [DL];
    rmq_pkg::t_branch             r_dl_br    [DL];
    logic [rmq_pkg::ROOT_W-2:0]   r_dl_half  [DL];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl_degen[0] <= s_side.degen;
            r_dl_br[0]    <= s_side.branch;
            r_dl_half[0]  <= s_root[rmq_pkg::ROOT_W-1:1];
            for (int k = 1; k < DL; k++) begin
                r_dl_degen[k] <= r_dl_degen[k-1];
                r_dl_br[k]    <= r_dl_br[k-1];
                r_dl_half[k]  <= r_dl_half[k-1];
            end
        end
    end

    // Saturate each quotient to the signed 16-bit range.
    logic [rmq_pkg::IN_W-1:0] sat [3];
    logic [rmq_pkg::IN_W-1:0] half16;
    logic [63:0]              n_data;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (d_quo[l].neg) begin
                if (d_quo[l].ovf || d_quo[l].q > rmq_pkg::Q_W'(32768)) begin
                    sat[l] = 16'h8000;
                end else begin
                    sat[l] = ~d_quo[l].q + 1'b1;
                end
            end else begin
                if (d_quo[l].ovf || d_quo[l].q > rmq_pkg::Q_W'(32767)) begin
                    sat[l] = 16'h7fff;
                end else begin
                    sat[l] = d_quo[l].q;
                end
            end
        end
        half16 = rmq_pkg::IN_W'(r_dl_half[DL-1]);
        case (r_dl_br[DL-1])
            rmq_pkg::BR_TRACE: n_data = {half16, sat[2], sat[1], sat[0]};
            rmq_pkg::BR_M00:   n_data = {sat[2], sat[1], sat[0], half16};
            rmq_pkg::BR_M11:   n_data = {sat[2], sat[1], half16, sat[0]};
            default:           n_data = {sat[2], half16, sat[1], sat[0]};
        endcase
        if (r_dl_degen[DL-1]) begin
            n_data = '0;
        end
    end

    logic        r_out_vld;
    logic [63:0] r_out_data;
    logic        r_out_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= d_vld[0];
        end
        if (en) begin
            r_out_data  <= n_data;
            r_out_degen <= r_dl_degen[DL-1];
        end
    end

    assign o_m_tvalid   = r_out_vld;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_degen;

    // A degenerate result carries an all-zero quaternion.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == 64'd0)
        else $error("degenerate result with non-zero quaternion");

    // The three divider lanes stay in lock step.
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_vld[0] == d_vld[1] && d_vld[0] == d_vld[2])
        else $error("divider lanes out of step");

    // A held result keeps the pipeline frozen behind it.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(d_vld) && $stable(s_vld))
        else $error("pipeline moved during a stall");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the matrix to quaternion converter.
// ----------------------------------------------------------------------------
// Matrices stream into the slave channel and quaternions are taken from the
// master channel, both sides pausing in random bursts. A table of directed
// matrices (identity, half turns, extremes, all-negative diagonals) runs
// first, then random rotations, near-rotations and raw noise. Every request
// taken on the output is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int N_RANDOM = 1100;
    localparam int LATENCY  = 34;

    typedef struct packed {
        logic signed [15:0] m22, m21, m20, m12, m11, m10, m02, m01, m00;
    } t_matrix;

    typedef struct packed {
        logic [15:0] qx, qy, qz, qw;
        logic        degen;
    } t_quat;

    // Directed row: the matrix, and optionally a result read straight off.
    typedef struct {
        t_matrix m;
        bit      known;
        t_quat   q;
    } t_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_s_tvalid = 1'b0;
    logic          o_s_tready;
    logic [143:0]  i_s_tdata = '0;
    logic          o_m_tvalid;
    logic          i_m_tready = 1'b0;
    logic [63:0]   o_m_tdata;
    logic [0:0]    o_m_tuser;

    t_quat  pending_quats[$];
    int     n_errors = 0;
    int     n_taken = 0;
    int     n_degen = 0;
    int     n_branch[4] = '{0, 0, 0, 0};
    bit     calm = 1'b0;

    always #4 i_clk = ~i_clk;

    rotation_matrix_to_quaternion dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Bitwise integer square root, floor.
    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   -= res + bitv;
                res  = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Scaled quotient, truncated toward zero (SystemVerilog / truncates).
    function automatic logic [15:0] scaled_quot(longint num, longint s);
        longint prod;
        prod = num * (longint'(1) << rmq_pkg::FRAC_BITS);
        return 16'(clip16(prod / s));
    endfunction

    function automatic t_quat quat_of(t_matrix m, output rmq_pkg::t_branch br);
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22, one, tr, rad, r, s;
        t_quat  q;
        logic [15:0] half;
        a00 = m.m00; a01 = m.m01; a02 = m.m02;
        a10 = m.m10; a11 = m.m11; a12 = m.m12;
        a20 = m.m20; a21 = m.m21; a22 = m.m22;
        one = longint'(1) << rmq_pkg::FRAC_BITS;
        tr  = one + a00 + a11 + a22;
        q   = '{16'd0, 16'd0, 16'd0, 16'd0, 1'b0};
        if (tr > 0) begin
            br = rmq_pkg::BR_TRACE; rad = tr;
        end else if (a00 > a11 && a00 > a22) begin
            br = rmq_pkg::BR_M00; rad = one + a00 - a11 - a22;
        end else if (a11 > a22) begin
            br = rmq_pkg::BR_M11; rad = one + a11 - a00 - a22;
        end else begin
            br = rmq_pkg::BR_M22; rad = one + a22 - a00 - a11;
        end
        if (rad <= 0) begin
            q.degen = 1'b1;
            return q;
        end
        r    = longint'(int_root(longint'(rad) << rmq_pkg::FRAC_BITS));
        s    = 2 * r;
        half = 16'(clip16(r >>> 1));
        case (br)
            rmq_pkg::BR_TRACE: begin
                q.qx = scaled_quot(a21 - a12, s);
                q.qy = scaled_quot(a02 - a20, s);
                q.qz = scaled_quot(a10 - a01, s);
                q.qw = half;
            end
            rmq_pkg::BR_M00: begin
                q.qx = half;
                q.qy = scaled_quot(a01 + a10, s);
                q.qz = scaled_quot(a02 + a20, s);
                q.qw = scaled_quot(a21 - a12, s);
            end
            rmq_pkg::BR_M11: begin
                q.qx = scaled_quot(a10 + a01, s);
                q.qy = half;
                q.qz = scaled_quot(a21 + a12, s);
                q.qw = scaled_quot(a02 - a20, s);
            end
            default: begin
                q.qx = scaled_quot(a02 + a20, s);
                q.qy = scaled_quot(a21 + a12, s);
                q.qz = half;
                q.qw = scaled_quot(a10 - a01, s);
            end
        endcase
        return q;
    endfunction

    function automatic t_matrix mat(int a, int b, int c, int d, int e, int f,
                                    int g, int h, int k);
        t_matrix m;
        m.m00 = 16'(a); m.m01 = 16'(b); m.m02 = 16'(c);
        m.m10 = 16'(d); m.m11 = 16'(e); m.m12 = 16'(f);
        m.m20 = 16'(g); m.m21 = 16'(h); m.m22 = 16'(k);
        return m;
    endfunction

    function automatic t_quat quat(int x, int y, int z, int w, bit dg);
        t_quat q;
        q.qx = 16'(x); q.qy = 16'(y); q.qz = 16'(z); q.qw = 16'(w); q.degen = dg;
        return q;
    endfunction

    // Random rotation-like matrix: a dominant diagonal pattern with jitter,
    // so that all four branches are hit with well-formed data.
    function automatic t_matrix random_rotation();
        t_matrix m;
        int      d[3];
        int      pick;
        pick = $urandom_range(0, 3);
        for (int i = 0; i < 3; i++)
            d[i] = $signed($urandom_range(0, 32767)) - 16384;
        if (pick != 0) begin
            // Two negative diagonal elements, with one non-negative element on top.
            d[0] = -$urandom_range(6000, 16384);
            d[1] = -$urandom_range(6000, 16384);
            d[2] = -$urandom_range(6000, 16384);
            d[pick - 1] = $urandom_range(0, 16384);
        end
        m.m00 = 16'(d[0]); m.m11 = 16'(d[1]); m.m22 = 16'(d[2]);
        m.m01 = 16'($signed($urandom_range(0, 32767)) - 16384);
        m.m02 = 16'($signed($urandom_range(0, 32767)) - 16384);
        m.m10 = 16'($signed($urandom_range(0, 32767)) - 16384);
        m.m12 = 16'($signed($urandom_range(0, 32767)) - 16384);
        m.m20 = 16'($signed($urandom_range(0, 32767)) - 16384);
        m.m21 = 16'($signed($urandom_range(0, 32767)) - 16384);
        return m;
    endfunction

    // Offers one matrix and holds it until the block takes it. The valid
    // line stays high between back-to-back requests and drops only for a gap.
    task automatic offer_matrix(t_matrix m, bit known, t_quat q);
        rmq_pkg::t_branch br;
        t_quat            predicted;
        predicted = quat_of(m, br);
        if (known && predicted != q) begin
            $error("table row disagrees with the predictor for %h", m);
            n_errors++;
        end
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= m;
        do @(posedge i_clk); while (!o_s_tready);
        pending_quats.push_back(known ? q : predicted);
        n_branch[br]++;
        if (predicted.degen) n_degen++;
    endtask

    // Receiver: stalls in random bursts, checks every quaternion taken.
    always @(posedge i_clk) begin
        t_quat got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.qx = o_m_tdata[15:0];
            got.qy = o_m_tdata[31:16];
            got.qz = o_m_tdata[47:32];
            got.qw = o_m_tdata[63:48];
            got.degen = o_m_tuser[0];
            n_taken++;
            if (pending_quats.size() == 0) begin
                $error("quaternion taken with none expected");
                n_errors++;
            end else begin
                want = pending_quats.pop_front();
                if (got.qx !== want.qx) begin
                    $error("qx: expected %h, got %h", want.qx, got.qx); n_errors++;
                end
                if (got.qy !== want.qy) begin
                    $error("qy: expected %h, got %h", want.qy, got.qy); n_errors++;
                end
                if (got.qz !== want.qz) begin
                    $error("qz: expected %h, got %h", want.qz, got.qz); n_errors++;
                end
                if (got.qw !== want.qw) begin
                    $error("qw: expected %h, got %h", want.qw, got.qw); n_errors++;
                end
                if (got.degen !== want.degen) begin
                    $error("degenerate: expected %b, got %b", want.degen, got.degen);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                stall--;
                i_m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 19) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        t_row    rows[$];
        t_matrix m;
        int      waited;
        // Identity, half turns about each axis, a quarter turn about z, and the extremes.
        rows.push_back('{mat(16384, 0, 0, 0, 16384, 0, 0, 0, 16384), 1'b1,
                         quat(0, 0, 0, 16384, 0)});
        rows.push_back('{mat(16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 1'b0, quat(0,0,0,0,0)});
        rows.push_back('{mat(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384), 1'b0, quat(0,0,0,0,0)});
        rows.push_back('{mat(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384), 1'b0, quat(0,0,0,0,0)});
        rows.push_back('{mat(0, -16384, 0, 16384, 0, 0, 0, 0, 16384), 1'b0, quat(0,0,0,0,0)});
        rows.push_back('{mat(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767),
                         1'b0, quat(0,0,0,0,0)});
        rows.push_back('{mat(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                             -32768), 1'b0, quat(0,0,0,0,0)});
        // Trace exactly zero and ties among the diagonal elements.
        rows.push_back('{mat(-16384, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, quat(0,0,0,0,0)});
        rows.push_back('{mat(-8192, 5, 7, 9, -8192, 11, 13, 15, -8192), 1'b0, quat(0,0,0,0,0)});
        rows.push_back('{mat(0, 0, 0, 0, 0, 0, 0, 0, -16384), 1'b0, quat(0,0,0,0,0)});
        // Diagonal branch with every diagonal element negative.
        rows.push_back('{mat(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 1'b0,
                         quat(0,0,0,0,0)});
        rows.push_back('{mat(-32768, 1, 2, 3, -32768, 4, 5, 6, -32768), 1'b0,
                         quat(0,0,0,0,0)});
        // A small radicand saturates the quotients, then each diagonal branch.
        rows.push_back('{mat(-16383, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0),
                         1'b0, quat(0,0,0,0,0)});
        rows.push_back('{mat(32767, -32768, 32767, 32767, -32768, -32768, -32768, 32767,
                             -32768), 1'b0, quat(0,0,0,0,0)});
        rows.push_back('{mat(-32768, 32767, 32767, 32767, 32767, -32768, -32768, -32768,
                             -32768), 1'b0, quat(0,0,0,0,0)});
        rows.push_back('{mat(-32768, -32768, 32767, 32767, -32768, 32767, -32768, 32767,
                             32767), 1'b0, quat(0,0,0,0,0)});
        rows.push_back('{mat(-16384, 1, -1, 1, -16384, -1, 1, -1, 1), 1'b0, quat(0,0,0,0,0)});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) offer_matrix(rows[i].m, rows[i].known, rows[i].q);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 150) calm = 1'b1;
            if ($urandom_range(0, 4) == 0) begin
                for (int k = 0; k < 9; k++) m[k*16 +: 16] = 16'($urandom);
            end else begin
                m = random_rotation();
            end
            offer_matrix(m, 1'b0, quat(0, 0, 0, 0, 0));
        end
        i_s_tvalid <= 1'b0;

        waited = 0;
        while (pending_quats.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (2 * LATENCY) @(posedge i_clk);

        $display("Checked %0d quaternions: %0d trace, %0d m00, %0d m11, %0d m22 branch.",
                 n_taken, n_branch[0], n_branch[1], n_branch[2], n_branch[3]);
        $display("Degenerate inputs among them: %0d.", n_degen);
        if (n_errors == 0 && pending_quats.size() == 0) begin
            $display("rotation_matrix_to_quaternion verification clean");
        end else begin
            $display("rotation_matrix_to_quaternion verification failed");
        end
        $finish;
    end

    // Far beyond the slowest correct run with every stall at its longest.
    initial begin
        #(8 * 200000);
        $display("rotation_matrix_to_quaternion verification failed");
        $finish;
    end

endmodule
